// File: rtl/hlsc_pkg.sv
// types and constants shared by the hoist limit switch controller
package hlsc_pkg;

	localparam int unsigned StirResetCount = 11;

	typedef enum logic [2:0] {
		MODE_STOPPED  = 3'd0,
		MODE_TOP      = 3'd1,
		MODE_BOTTOM   = 3'd2,
		MODE_UP       = 3'd3,
		MODE_DOWN     = 3'd4,
		MODE_STEPWISE = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		CMD_STOP     = 3'd0,
		CMD_UP       = 3'd1,
		CMD_DOWN     = 3'd2,
		CMD_STEPWISE = 3'd3,
		CMD_NONE     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		DRV_OFF  = 2'd0,
		DRV_UP   = 2'd1,
		DRV_DOWN = 2'd2
	} drv_t;

	localparam logic [1:0] NUDGE_NONE = 2'd0;
	localparam logic [1:0] NUDGE_STEP = 2'd1;
	localparam logic [1:0] NUDGE_SEAT = 2'd2;

	localparam logic [1:0] STIR_NONE  = 2'd0;
	localparam logic [1:0] STIR_START = 2'd1;
	localparam logic [1:0] STIR_STOP  = 2'd2;

	typedef struct packed {
		mode_t       mode;
		cmd_t        pend;
		logic        report;
		logic        done;
		logic [7:0]  tag;
		logic [7:0]  count;
		drv_t        drive;
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [1:0]  command;
		logic [7:0]  step_number;
		logic        from_sequencer;
		logic        upper_limit;
		logic        lower_limit;
	} item_t;

	typedef struct packed {
		logic [2:0]  crane_status;
		logic [7:0]  completed_step;
		logic        step_complete;
		logic [1:0]  stir_request;
		logic [1:0]  nudge;
		logic [1:0]  motor_drive;
	} result_t;

endpackage

// File: rtl/hlsc_step.sv
// one mode decision: next state and result for one input item
module hlsc_step (
	input  hlsc_pkg::state_t  state,
	input  hlsc_pkg::item_t   item,
	input  logic [7:0]        stir_start_count,
	output hlsc_pkg::state_t  state_nxt,
	output hlsc_pkg::result_t result
);

	hlsc_pkg::state_t  st;
	hlsc_pkg::cmd_t    cmd;
	logic [1:0]        nudge;
	logic [1:0]        stir;
	logic              complete;
	logic [7:0]        tag;

	always_comb begin
		st       = state;
		nudge    = hlsc_pkg::NUDGE_NONE;
		stir     = hlsc_pkg::STIR_NONE;
		complete = 1'b0;
		tag      = 8'd0;

		// a new command replaces the latched one
		if (item.operation) begin
			st.pend   = hlsc_pkg::cmd_t'({1'b0, item.command});
			st.tag    = item.step_number;
			st.report = item.from_sequencer;
			st.done   = 1'b0;
			st.count  = 8'd0;
		end
		cmd = st.pend;

		unique case (state.mode)
			hlsc_pkg::MODE_TOP: begin
				if (cmd == hlsc_pkg::CMD_DOWN) begin
					st.drive = hlsc_pkg::DRV_DOWN;
					st.done  = 1'b0;
					st.mode  = hlsc_pkg::MODE_DOWN;
				end else if (cmd == hlsc_pkg::CMD_STEPWISE) begin
					st.mode = hlsc_pkg::MODE_STEPWISE;
				end else if (cmd == hlsc_pkg::CMD_UP) begin
					st.done = 1'b1;
				end
			end
			hlsc_pkg::MODE_BOTTOM: begin
				if (cmd == hlsc_pkg::CMD_UP) begin
					st.drive = hlsc_pkg::DRV_UP;
					st.mode  = hlsc_pkg::MODE_UP;
					st.done  = 1'b0;
				end else if (cmd == hlsc_pkg::CMD_DOWN) begin
					st.done = 1'b1;
				end
			end
			hlsc_pkg::MODE_UP: begin
				if (cmd == hlsc_pkg::CMD_STOP) begin
					st.drive = hlsc_pkg::DRV_OFF;
					st.mode  = hlsc_pkg::MODE_STOPPED;
					st.done  = 1'b1;
				end else if (cmd == hlsc_pkg::CMD_DOWN) begin
					if (!item.lower_limit) begin
						st.drive = hlsc_pkg::DRV_DOWN;
						st.mode  = hlsc_pkg::MODE_DOWN;
					end else begin
						// already at the bottom: drive left as it is
						st.mode = hlsc_pkg::MODE_BOTTOM;
						st.done = 1'b1;
					end
				end else if (item.upper_limit) begin
					st.drive = hlsc_pkg::DRV_OFF;
					st.mode  = hlsc_pkg::MODE_TOP;
					st.done  = 1'b1;
				end
			end
			hlsc_pkg::MODE_DOWN: begin
				if (cmd == hlsc_pkg::CMD_STOP) begin
					st.drive = hlsc_pkg::DRV_OFF;
					st.mode  = hlsc_pkg::MODE_STOPPED;
					st.done  = 1'b1;
				end else if (cmd == hlsc_pkg::CMD_UP) begin
					if (item.upper_limit) begin
						st.mode = hlsc_pkg::MODE_TOP;
						st.done = 1'b1;
					end else begin
						st.drive = hlsc_pkg::DRV_UP;
						st.mode  = hlsc_pkg::MODE_UP;
						st.done  = 1'b0;
					end
				end else if (item.lower_limit) begin
					st.drive = hlsc_pkg::DRV_OFF;
					st.mode  = hlsc_pkg::MODE_BOTTOM;
					st.done  = 1'b1;
				end
			end
			hlsc_pkg::MODE_STEPWISE: begin
				st.drive = hlsc_pkg::DRV_OFF;
				if (!item.lower_limit) begin
					nudge    = hlsc_pkg::NUDGE_STEP;
					st.count = st.count + 8'd1;
				end else begin
					nudge    = hlsc_pkg::NUDGE_SEAT;
					st.mode  = hlsc_pkg::MODE_BOTTOM;
					st.done  = 1'b1;
					st.count = 8'd0;
					stir     = hlsc_pkg::STIR_STOP;
				end
				// start wins over stop
				if (st.count == stir_start_count) begin
					stir = hlsc_pkg::STIR_START;
				end
			end
			hlsc_pkg::MODE_STOPPED: begin
				if (cmd == hlsc_pkg::CMD_UP) begin
					if (!item.upper_limit) begin
						st.done  = 1'b0;
						st.drive = hlsc_pkg::DRV_UP;
						st.mode  = hlsc_pkg::MODE_UP;
					end else begin
						st.done = 1'b1;
						st.mode = hlsc_pkg::MODE_TOP;
					end
				end else if (cmd == hlsc_pkg::CMD_DOWN || cmd == hlsc_pkg::CMD_STEPWISE) begin
					if (!item.lower_limit) begin
						st.done = 1'b0;
						if (cmd == hlsc_pkg::CMD_DOWN) begin
							st.drive = hlsc_pkg::DRV_DOWN;
							st.mode  = hlsc_pkg::MODE_DOWN;
						end else begin
							st.mode = hlsc_pkg::MODE_STEPWISE;
						end
					end else begin
						st.done = 1'b1;
						st.mode = hlsc_pkg::MODE_BOTTOM;
					end
				end
				st.pend = hlsc_pkg::CMD_NONE;
			end
			default: begin
				st.drive = hlsc_pkg::DRV_OFF;
				st.mode  = hlsc_pkg::MODE_STOPPED;
			end
		endcase

		// completion report to the sequencer
		if (st.done && st.report) begin
			complete = 1'b1;
			tag      = st.tag;
			st.done  = 1'b0;
			st.mode  = hlsc_pkg::MODE_STOPPED;
		end
	end

	assign state_nxt = st;

	always_comb begin
		result.motor_drive    = st.drive;
		result.nudge          = nudge;
		result.stir_request   = stir;
		result.step_complete  = complete;
		result.completed_step = tag;
		if (item.lower_limit) begin
			result.crane_status = hlsc_pkg::MODE_BOTTOM;
		end else if (item.upper_limit) begin
			result.crane_status = hlsc_pkg::MODE_TOP;
		end else begin
			result.crane_status = st.mode;
		end
	end

endmodule

// File: rtl/hoist_limit_switch_controller.sv
// hoist limit switch controller: top level with state and result registers
//
// s_* carries one item per accept: a command or a poll tick (tuser) plus
// both limit switch levels. m_* returns exactly one result item per input
// item, in order. cfg_* writes the stirrer start count; it is always ready,
// and the user must write it only while the block is idle; the block itself
// does not enforce this. The result of an item accepted at an edge is
// registered and is on m_* from that edge on. The block takes one item per
// cycle while m_tready is high; the mode decision is one pass of logic
// from the state register and the item into the state and result registers.
// s_tready is high while the result register is empty or is being emptied
// in the same cycle, so a stalled receiver holds the result and stops intake
// after one item; nothing is dropped.
// arst_n clears the mode to stopped, the latched command to stop, the drive
// to off, counters and flags to zero, the stirrer count to eleven, and
// empties the result register.
module hoist_limit_switch_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [0:0]  s_tuser,   // operation
	// command[1:0], step_number[9:2], from_sequencer[10], upper_limit[11],
	// lower_limit[12], zero fill
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// motor_drive[1:0], nudge[3:2], stir_request[5:4], step_complete[6],
	// completed_step[14:7], crane_status[17:15], zero fill
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	hlsc_pkg::state_t  state_q;
	hlsc_pkg::state_t  state_nxt;
	hlsc_pkg::item_t   item;
	hlsc_pkg::result_t result;
	hlsc_pkg::result_t result_q;
	logic [7:0]        stir_start_q;
	logic              s_accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid || m_tready;
	assign s_accept  = s_tvalid && s_tready;

	assign item.operation      = s_tuser[0];
	assign item.command        = s_tdata[1:0];
	assign item.step_number    = s_tdata[9:2];
	assign item.from_sequencer = s_tdata[10];
	assign item.upper_limit    = s_tdata[11];
	assign item.lower_limit    = s_tdata[12];

	hlsc_step u_step (
		.state            (state_q),
		.item             (item),
		.stir_start_count (stir_start_q),
		.state_nxt        (state_nxt),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stir_start_q <= 8'(hlsc_pkg::StirResetCount);
		end else if (cfg_valid && cfg_ready) begin
			stir_start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= hlsc_pkg::MODE_STOPPED;
			state_q.pend   <= hlsc_pkg::CMD_STOP;
			state_q.report <= 1'b0;
			state_q.done   <= 1'b0;
			state_q.tag    <= 8'd0;
			state_q.count  <= 8'd0;
			state_q.drive  <= hlsc_pkg::DRV_OFF;
		end else if (s_accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			result_q <= result;
		end
	end

	assign m_tdata = {6'd0, result_q};

	// a completion report always leaves the block stopped
	a_report_stops: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && result.step_complete |=> state_q.mode == hlsc_pkg::MODE_STOPPED)
		else $error("mode not stopped after completion report");

	// no report, no tag
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !result_q.step_complete |-> result_q.completed_step == 8'd0)
		else $error("completed step tag without report");

	// nudges only come with the held drive off
	a_nudge_drive_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q.nudge != hlsc_pkg::NUDGE_NONE |->
		result_q.motor_drive == hlsc_pkg::DRV_OFF)
		else $error("nudge while motor drive held");

	// every accepted item leaves a result behind
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_tvalid)
		else $error("accepted item produced no result");

	// the state only moves when an item is taken
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_accept |=> $stable(state_q))
		else $error("state changed without an item");

endmodule
